>>> sv/ats_pkg.sv
// ----------------------------------------------------------------------------
// Animation timeline sampler package
// Shared register indexes, mode codes and pipeline control types.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int DUR_BITS = 31;
  localparam int ITER_BITS = 31;
  localparam int COUNT_INT_BITS = 16;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam logic [2:0] REG_DELAY = 3'd0;
  localparam logic [2:0] REG_DURATION = 3'd1;
  localparam logic [2:0] REG_COUNT = 3'd2;
  localparam logic [2:0] REG_INFINITE = 3'd3;
  localparam logic [2:0] REG_DIRECTION = 3'd4;
  localparam logic [2:0] REG_FILL = 3'd5;

  localparam logic [1:0] DIR_NORMAL = 2'd0;
  localparam logic [1:0] DIR_REVERSE = 2'd1;
  localparam logic [1:0] DIR_ALTERNATE = 2'd2;
  localparam logic [1:0] DIR_ALT_REVERSE = 2'd3;

  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_FORWARDS = 2'd1;
  localparam logic [1:0] FILL_BACKWARDS = 2'd2;
  localparam logic [1:0] FILL_BOTH = 2'd3;

  typedef struct packed {
    logic       count_infinite;
    logic [1:0] direction;
    logic [1:0] fill;
  } ats_mode_t;

  typedef struct packed {
    logic valid;
    logic early;
    logic terminal;
  } ats_ctrl_t;

endpackage

>>> sv/ats_ifs.sv
// ----------------------------------------------------------------------------
// Animation timeline sampler channels
// Valid/ready interfaces for the time input and the sample result.
// ----------------------------------------------------------------------------
interface ats_in_if #(parameter int TIME_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [TIME_BITS-1:0] elapsed_ticks;
  modport source (output valid, elapsed_ticks, input ready);
  modport sink (input valid, elapsed_ticks, output ready);
endinterface

interface ats_out_if #(parameter int PROGRESS_BITS = 16);
  logic                     valid;
  logic                     ready;
  logic [30:0]              iteration_number;
  logic [PROGRESS_BITS:0]   progress;
  logic                     is_active;
  logic                     pre_start;
  logic                     past_end;
  logic                     is_finished;
  modport source (output valid, iteration_number, progress, is_active, pre_start,
                  past_end, is_finished, input ready);
  modport sink (input valid, iteration_number, progress, is_active, pre_start,
                past_end, is_finished, output ready);
endinterface

>>> sv/animation_timeline_sampler_unit.sv
// ----------------------------------------------------------------------------
// Animation timeline sampler
// Maps an elapsed time to iteration, directed progress and phase flags.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake     | payload
//  in_ch    | in        | valid/ready   | elapsed_ticks
//  out_ch   | out       | valid/ready   | iteration_number, progress, four flags
//  psel..   | in/out    | APB, no waits | six configuration registers
//
// One word is accepted per cycle unless the output word is stalled; the row of
// divider cells yields one quotient bit per cell.
// The whole pipeline holds when the output word is stalled; in_ch.ready is low
// only then. Reset is synchronous and resets the valid flags and the settings.
// ----------------------------------------------------------------------------
module animation_timeline_sampler_unit import ats_pkg::*; #(
  parameter int TIME_BITS = 32,
  parameter int COUNT_FRAC_BITS = 8,
  parameter int PROGRESS_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ats_in_if.sink               in_ch,
  ats_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int TW = TIME_BITS - 1;
  localparam int QB = TW + PROGRESS_BITS;
  localparam int CB = COUNT_INT_BITS + COUNT_FRAC_BITS;
  localparam int LW = DUR_BITS + COUNT_INT_BITS;
  localparam int CW = (TW > LW) ? TW : LW;
  localparam int SW = ((TW > DUR_BITS) ? TW : DUR_BITS) + 1;
  localparam int IW = (TW > ITER_BITS) ? TW : ITER_BITS;
  localparam int PB = PROGRESS_BITS + 1;
  localparam logic [PB-1:0] ONE = PB'(1) << PROGRESS_BITS;

  logic [DUR_BITS-1:0] delay;
  logic [DUR_BITS-1:0] duration;
  logic [CB-1:0]       count;
  ats_mode_t           mode;
  logic [LW-1:0]       limit;

  ats_cfg #(.COUNT_FRAC_BITS(COUNT_FRAC_BITS)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .delay, .duration, .count, .mode, .limit
  );

  logic en;
  logic out_valid_r;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Input stage: clamp negative times to zero.
  logic          s0_valid_r;
  logic [TW-1:0] t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= in_ch.elapsed_ticks[TW] ? '0 : in_ch.elapsed_ticks[TW-1:0];
    end
  end

  // Delay stage: a borrow out of the subtraction means the time lies in the delay.
  logic [SW-1:0] s0_diff;
  logic          s1_valid_r;
  logic          s1_before_r;
  logic [TW-1:0] a_r;

  assign s0_diff = SW'(t_r) - SW'(delay);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_before_r <= s0_diff[SW-1];
      a_r         <= s0_diff[TW-1:0];
    end
  end

  logic      s1_terminal;
  ats_ctrl_t s1_ctrl;

  assign s1_terminal = (duration == '0) ||
                       (!mode.count_infinite && (CW'(a_r) >= CW'(limit)));
  assign s1_ctrl = '{valid: s1_valid_r, early: s1_before_r, terminal: s1_terminal};

  // Row of divider cells: {a, 0} / duration gives iteration and fraction at once.
  logic [DUR_BITS-1:0] rem_l [0:QB];
  logic [QB-1:0]       qd_l [0:QB];
  ats_ctrl_t           ctrl_l [0:QB];

  assign rem_l[0]  = '0;
  assign qd_l[0]   = {a_r, {PROGRESS_BITS{1'b0}}};
  assign ctrl_l[0] = s1_ctrl;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    ats_cell #(.QB(QB)) u_cell (
      .clk, .rst_n, .en, .divisor(duration),
      .rem_i(rem_l[i]), .qd_i(qd_l[i]), .ctrl_i(ctrl_l[i]),
      .rem_o(rem_l[i+1]), .qd_o(qd_l[i+1]), .ctrl_o(ctrl_l[i+1])
    );
  end

  // Terminal point from the count, with its fraction scaled to 16 bits.
  logic [31:0]             cnt_ext;
  logic [15:0]             frac16;
  logic [15:0]             whole;
  logic [31:0]             lo_chk;
  logic [31:0]             hi_chk;
  logic [39:0]             frac_sh;
  logic [ITER_BITS-1:0]    end_iter;
  logic [PB-1:0]           end_raw;

  assign cnt_ext = 32'(count) << (16 - COUNT_FRAC_BITS);
  assign frac16  = cnt_ext[15:0];
  assign whole   = cnt_ext[31:16];
  assign lo_chk  = 32'(frac16) * 32'd10000;
  assign hi_chk  = (32'h10000 - 32'(frac16)) * 32'd10000;
  assign frac_sh = 40'(frac16) << PROGRESS_BITS;

  always_comb begin
    if (mode.count_infinite) begin
      end_iter = '0;
      end_raw  = ONE;
    end else if (lo_chk <= 32'h10000) begin
      end_iter = (whole > 16'd1) ? ITER_BITS'(whole - 16'd1) : '0;
      end_raw  = ONE;
    end else if (hi_chk <= 32'h10000) begin
      end_iter = ITER_BITS'(whole);
      end_raw  = ONE;
    end else begin
      end_iter = ITER_BITS'(whole);
      end_raw  = PB'(frac_sh >> 16);
    end
  end

  // Output stage.
  ats_ctrl_t            last_ctrl;
  logic [IW-1:0]        div_iter;
  logic [ITER_BITS-1:0] iter_sel;
  logic [PB-1:0]        raw_sel;
  logic                 fwd;
  logic [PB-1:0]        prog_nxt;
  logic                 active_nxt;

  assign last_ctrl = ctrl_l[QB];
  assign div_iter  = IW'(qd_l[QB][QB-1:PROGRESS_BITS]);

  always_comb begin
    if (last_ctrl.early) begin
      iter_sel   = '0;
      raw_sel    = '0;
      active_nxt = (mode.fill == FILL_BACKWARDS) || (mode.fill == FILL_BOTH);
    end else if (last_ctrl.terminal) begin
      iter_sel   = end_iter;
      raw_sel    = end_raw;
      active_nxt = (mode.fill == FILL_FORWARDS) || (mode.fill == FILL_BOTH);
    end else begin
      iter_sel   = (div_iter > IW'({ITER_BITS{1'b1}})) ? {ITER_BITS{1'b1}}
                                                        : div_iter[ITER_BITS-1:0];
      raw_sel    = PB'(qd_l[QB][PROGRESS_BITS-1:0]);
      active_nxt = 1'b1;
    end
  end

  always_comb begin
    case (mode.direction)
      DIR_NORMAL:      fwd = 1'b1;
      DIR_REVERSE:     fwd = 1'b0;
      DIR_ALTERNATE:   fwd = !iter_sel[0];
      DIR_ALT_REVERSE: fwd = iter_sel[0];
      default:         fwd = 1'b1;
    endcase
  end

  assign prog_nxt = fwd ? raw_sel : ONE - raw_sel;

  logic [ITER_BITS-1:0] iter_r;
  logic [PB-1:0]        prog_r;
  logic                 active_r;
  logic                 before_r;
  logic                 after_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iter_r   <= iter_sel;
      prog_r   <= prog_nxt;
      active_r <= active_nxt;
      before_r <= last_ctrl.early;
      after_r  <= !last_ctrl.early && last_ctrl.terminal;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.iteration_number = iter_r;
  assign out_ch.progress         = prog_r;
  assign out_ch.is_active        = active_r;
  assign out_ch.pre_start        = before_r;
  assign out_ch.past_end         = after_r;
  assign out_ch.is_finished      = after_r;

  a_before_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && before_r |-> !after_r && (iter_r == '0))
    else $error("word in the delay carries an end flag or a non-zero iteration");

  a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> prog_r <= ONE)
    else $error("progress exceeds one");

  a_running_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !before_r && !after_r |-> active_r)
    else $error("word inside the active span is not active");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(iter_r) && $stable(prog_r))
    else $error("stalled output word changed");

endmodule

>>> sv/ats_cfg.sv
// ----------------------------------------------------------------------------
// Animation timeline sampler configuration
// APB register file and the registered end-of-active-span limit.
// ----------------------------------------------------------------------------
module ats_cfg import ats_pkg::*; #(
  parameter int COUNT_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ADDR_BITS-1:0]                  paddr,
  input  logic [DATA_BITS-1:0]                  pwdata,
  output logic [DATA_BITS-1:0]                  prdata,
  output logic                                  pready,
  output logic [DUR_BITS-1:0]                   delay,
  output logic [DUR_BITS-1:0]                   duration,
  output logic [COUNT_INT_BITS+COUNT_FRAC_BITS-1:0] count,
  output ats_mode_t                             mode,
  output logic [DUR_BITS+COUNT_INT_BITS-1:0]    limit
);

  localparam int CB = COUNT_INT_BITS + COUNT_FRAC_BITS;
  localparam int PW = DUR_BITS + CB;
  localparam int LW = DUR_BITS + COUNT_INT_BITS;

  logic [DUR_BITS-1:0] delay_r;
  logic [DUR_BITS-1:0] duration_r;
  logic [CB-1:0]       count_r;
  ats_mode_t           mode_r;
  logic [PW-1:0]       prod_r;
  logic [LW-1:0]       limit_r;
  logic                wr_en;
  logic [2:0]          idx;
  logic [PW-1:0]       rounded;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= '0;
      duration_r <= '0;
      count_r    <= CB'(1) << COUNT_FRAC_BITS;
      mode_r     <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_DELAY:     delay_r <= pwdata[DUR_BITS-1:0];
        REG_DURATION:  duration_r <= pwdata[DUR_BITS-1:0];
        REG_COUNT:     count_r <= pwdata[CB-1:0];
        REG_INFINITE:  mode_r.count_infinite <= pwdata[0];
        REG_DIRECTION: mode_r.direction <= pwdata[1:0];
        REG_FILL:      mode_r.fill <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // The span is rounded up so that a whole-tick compare matches the fixed-point one.
  assign rounded = prod_r + PW'((1 << COUNT_FRAC_BITS) - 1);

  always_ff @(posedge clk) begin
    prod_r  <= PW'(duration_r) * PW'(count_r);
    limit_r <= LW'(rounded >> COUNT_FRAC_BITS);
  end

  always_comb begin
    case (idx)
      REG_DELAY:     prdata = DATA_BITS'(delay_r);
      REG_DURATION:  prdata = DATA_BITS'(duration_r);
      REG_COUNT:     prdata = DATA_BITS'(count_r);
      REG_INFINITE:  prdata = DATA_BITS'(mode_r.count_infinite);
      REG_DIRECTION: prdata = DATA_BITS'(mode_r.direction);
      REG_FILL:      prdata = DATA_BITS'(mode_r.fill);
      default:       prdata = '0;
    endcase
  end

  assign delay    = delay_r;
  assign duration = duration_r;
  assign count    = count_r;
  assign mode     = mode_r;
  assign limit    = limit_r;

endmodule

>>> sv/ats_cell.sv
// ----------------------------------------------------------------------------
// Animation timeline sampler divider cell
// One restoring division step; hands remainder and quotient to the next cell.
// ----------------------------------------------------------------------------
module ats_cell import ats_pkg::*; #(
  parameter int QB = 47
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [DUR_BITS-1:0] divisor,
  input  logic [DUR_BITS-1:0] rem_i,
  input  logic [QB-1:0]       qd_i,
  input  ats_ctrl_t           ctrl_i,
  output logic [DUR_BITS-1:0] rem_o,
  output logic [QB-1:0]       qd_o,
  output ats_ctrl_t           ctrl_o
);

  logic [DUR_BITS:0]   trial;
  logic [DUR_BITS:0]   diff;
  logic                ge;
  logic [DUR_BITS-1:0] rem_nxt;
  logic [DUR_BITS-1:0] rem_r;
  logic [QB-1:0]       qd_r;
  ats_ctrl_t           ctrl_r;

  // The top of qd holds dividend bits still to come, the bottom the quotient so far.
  assign trial   = {rem_i, qd_i[QB-1]};
  assign diff    = trial - {1'b0, divisor};
  assign ge      = trial >= {1'b0, divisor};
  assign rem_nxt = ge ? diff[DUR_BITS-1:0] : trial[DUR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      qd_r  <= {qd_i[QB-2:0], ge};
    end
  end

  assign rem_o  = rem_r;
  assign qd_o   = qd_r;
  assign ctrl_o = ctrl_r;

endmodule

>>> test/ats_test_ifs.sv
// ----------------------------------------------------------------------------
// Sampler test channel helpers
// Holds the types that the test uses for its timing settings and expected samples.
// ----------------------------------------------------------------------------
package ats_test_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [30:0] iteration_number;
    logic [16:0] progress;
    logic        is_active;
    logic        pre_start;
    logic        past_end;
    logic        is_finished;
  } sample_t;

  typedef struct {
    logic [30:0] delay;
    logic [30:0] duration;
    logic [23:0] count;
    logic        infinite;
    logic [1:0]  direction;
    logic [1:0]  fill;
  } timing_cfg_t;
endpackage

>>> test/animation_timeline_sampler_unit_test.sv
// ----------------------------------------------------------------------------
// Animation timeline sampler regression
// Drives elapsed times through several timing settings under random idling,
// predicts each sample independently and compares every output word.
// ----------------------------------------------------------------------------
module animation_timeline_sampler_unit_test
  import ats_pkg::*, ats_test_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 31 + 16 + 3;
  localparam int HOLD_CYCLES = 400;
  localparam logic [16:0] ONE_PROG = 17'h10000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  ats_in_if #(.TIME_BITS(32)) in_ch ();
  ats_out_if #(.PROGRESS_BITS(16)) out_ch ();

  animation_timeline_sampler_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  timing_cfg_t cfg;
  logic signed [31:0] pending_times[$];
  sample_t expected_samples[$];
  int error_count = 0;
  bit feed_enable = 1'b0;
  bit hold_req = 1'b0;
  int hold_cycles = 0;
  int burst_left = 0, gap_left = 0, stall_phase = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.elapsed_ticks = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  task automatic queue_time(input logic signed [31:0] value);
    pending_times = {pending_times, value};
  endtask

  function automatic logic [16:0] directed(input logic [16:0] raw,
                                           input logic [30:0] iter);
    logic fwd;
    case (cfg.direction)
      DIR_NORMAL: fwd = 1'b1;
      DIR_REVERSE: fwd = 1'b0;
      DIR_ALTERNATE: fwd = ~iter[0];
      default: fwd = iter[0];
    endcase
    return fwd ? raw : ONE_PROG - raw;
  endfunction

  function automatic sample_t sample_time(input logic signed [31:0] elapsed);
    sample_t s;
    logic [63:0] t, a, limit, whole, frac;
    logic [30:0] iter;
    logic [16:0] raw;
    logic terminal;
    s = '0;
    t = elapsed < 0 ? 64'd0 : 64'(elapsed);
    if (t < 64'(cfg.delay)) begin
      s.pre_start = 1'b1;
      s.is_active = cfg.fill inside {FILL_BACKWARDS, FILL_BOTH};
      s.progress = directed(17'd0, 31'd0);
    end else begin
      a = t - 64'(cfg.delay);
      terminal = (cfg.duration == 31'd0);
      if (!terminal && !cfg.infinite) begin
        limit = (64'(cfg.duration) * 64'(cfg.count) + 64'd255) >> 8;
        terminal = a >= limit;
      end
      if (terminal) begin
        whole = 64'(cfg.count[23:8]);
        frac = 64'(cfg.count[7:0]);
        if (cfg.infinite) begin
          iter = 31'd0; raw = ONE_PROG;
        end else if (frac == 64'd0) begin
          // A whole count ends on its last iteration at full progress.
          iter = whole > 64'd1 ? 31'(whole - 64'd1) : 31'd0; raw = ONE_PROG;
        end else begin
          iter = 31'(whole); raw = 17'(frac << 8);
        end
        s.iteration_number = iter;
        s.progress = directed(raw, iter);
        s.is_active = cfg.fill inside {FILL_FORWARDS, FILL_BOTH};
        s.past_end = 1'b1;
        s.is_finished = 1'b1;
      end else begin
        iter = 31'(a / 64'(cfg.duration));
        raw = 17'(((a % 64'(cfg.duration)) << 16) / 64'(cfg.duration));
        s.iteration_number = iter;
        s.progress = directed(raw, iter);
        s.is_active = 1'b1;
      end
    end
    return s;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_BITS'({idx, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DELAY: cfg.delay = value[30:0];
      REG_DURATION: cfg.duration = value[30:0];
      REG_COUNT: cfg.count = value[23:0];
      REG_INFINITE: cfg.infinite = value[0];
      REG_DIRECTION: cfg.direction = value[1:0];
      REG_FILL: cfg.fill = value[1:0];
      default: ;
    endcase
  endtask

  task automatic program_all(input timing_cfg_t c);
    write_reg(REG_DELAY, 32'(c.delay));
    write_reg(REG_DURATION, 32'(c.duration));
    write_reg(REG_COUNT, 32'(c.count));
    write_reg(REG_INFINITE, 32'(c.infinite));
    write_reg(REG_DIRECTION, 32'(c.direction));
    write_reg(REG_FILL, 32'(c.fill));
  endtask

  task automatic drain_and_settle();
    wait (pending_times.size() == 0 && expected_samples.size() == 0 && !in_ch.valid);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] time_near(input timing_cfg_t c);
    logic [63:0] span, base;
    span = (64'(c.duration) * 64'(c.count) + 64'd255) >> 8;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return -($urandom_range(0, 1000));
      2: base = 64'(c.delay);
      3: base = 64'(c.delay) + span;
      4: base = 64'(c.delay) + 64'(c.duration) * 64'($urandom_range(0, 4));
      default: base = 64'(c.delay) + ((span == 0) ? 64'd0 : (64'($urandom) % (span + 1)));
    endcase
    base = base + 64'($urandom_range(0, 4)) - 64'd2;
    return base > 64'h7fffffff ? 32'h7fffffff : 32'(base);
  endfunction

  function automatic timing_cfg_t random_cfg();
    timing_cfg_t c;
    c.delay = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 200));
    case ($urandom_range(0, 5))
      0: c.duration = 31'd0;
      1: c.duration = 31'($urandom);
      2: c.duration = 31'd1;
      default: c.duration = 31'($urandom_range(1, 5000));
    endcase
    case ($urandom_range(0, 4))
      0: c.count = 24'($urandom_range(1, 8)) << 8;
      1: c.count = 24'($urandom);
      2: c.count = 24'($urandom_range(0, 255));
      default: c.count = 24'($urandom_range(1, 2048));
    endcase
    c.infinite = $urandom_range(0, 3) == 0;
    c.direction = 2'($urandom);
    c.fill = 2'($urandom);
    return c;
  endfunction

  // Sender: bursts of words separated by random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_samples = {expected_samples, sample_time(in_ch.elapsed_ticks)};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (feed_enable && pending_times.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.elapsed_ticks <= pending_times.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus a long hold-off counted here when requested.
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= stall_phase + 1;
      if (hold_req && hold_cycles < HOLD_CYCLES) begin
        hold_cycles <= hold_cycles + 1;
        out_ch.ready <= 1'b0;
      end else if (stall_phase[8]) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected word", 32'd0, 32'd0);
        end else begin
          sample_t e;
          e = expected_samples.pop_front();
          if (out_ch.iteration_number !== e.iteration_number)
            report_mismatch("iteration_number", 32'(out_ch.iteration_number),
                            32'(e.iteration_number));
          if (out_ch.progress !== e.progress)
            report_mismatch("progress", 32'(out_ch.progress), 32'(e.progress));
          if (out_ch.is_active !== e.is_active)
            report_mismatch("is_active", 32'(out_ch.is_active), 32'(e.is_active));
          if (out_ch.pre_start !== e.pre_start)
            report_mismatch("pre_start", 32'(out_ch.pre_start), 32'(e.pre_start));
          if (out_ch.past_end !== e.past_end)
            report_mismatch("past_end", 32'(out_ch.past_end), 32'(e.past_end));
          if (out_ch.is_finished !== e.is_finished)
            report_mismatch("is_finished", 32'(out_ch.is_finished),
                            32'(e.is_finished));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    timing_cfg_t c;
    logic signed [31:0] edge_times[$];
    cfg.delay = 0; cfg.duration = 0; cfg.count = 24'h100;
    cfg.infinite = 0; cfg.direction = DIR_NORMAL; cfg.fill = FILL_NONE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fractional count, alternate direction, fill both.
    c.delay = 100; c.duration = 1000; c.count = 24'h0280; c.infinite = 0;
    c.direction = DIR_ALTERNATE; c.fill = FILL_BOTH;
    program_all(c);
    edge_times = {32'sh80000000, -1, 0, 99, 100, 101, 1099, 1100, 2099, 2100,
                  2599, 2600, 2601, 32'sh7fffffff};
    foreach (edge_times[i]) queue_time(edge_times[i]);
    feed_enable = 1'b1;
    drain_and_settle();

    // Directed: zero duration, infinite count and zero count extremes.
    c.delay = 31'h7fffffff; c.duration = 0; c.count = 0; c.infinite = 1;
    c.direction = DIR_ALT_REVERSE; c.fill = FILL_BACKWARDS;
    program_all(c);
    queue_time(0);
    queue_time(32'sh7fffffff);
    drain_and_settle();
    c.delay = 0; c.duration = 31'h7fffffff; c.count = 24'hffffff; c.infinite = 0;
    c.direction = DIR_REVERSE; c.fill = FILL_FORWARDS;
    program_all(c);
    queue_time(32'sh7fffffff);
    queue_time(12345);
    c.count = 0;
    drain_and_settle();
    program_all(c);
    queue_time(0);
    queue_time(-5);
    drain_and_settle();

    // Long receiver hold-off while the sender keeps offering words.
    hold_req = 1'b1;
    for (int i = 0; i < 120; i++) queue_time(time_near(c));
    wait (hold_cycles >= HOLD_CYCLES);
    hold_req = 1'b0;
    drain_and_settle();

    // Random phases, each under a fresh setting.
    for (int phase = 0; phase < 12; phase++) begin
      c = random_cfg();
      program_all(c);
      for (int i = 0; i < 60; i++) queue_time(time_near(c));
      drain_and_settle();
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
